// ===== hw/rtl/touch_point_smoother_macros.svh =====
// Assertion macros shared by the touch point smoother checkers.
// Needs nothing but a clock and a reset signal at the place of use.
`ifndef TOUCH_POINT_SMOOTHER_MACROS_SVH
`define TOUCH_POINT_SMOOTHER_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define TPS_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define TPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tps_pkg.sv =====
// Package for the touch point smoother: payload types, register codes
// and the averaging function. Depends on nothing.
package tps_pkg;

  localparam int COORD_BITS = 12;
  localparam int SHIFT_BITS = 4;
  localparam int ACC_BITS   = COORD_BITS + (1 << SHIFT_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SHIFT_BITS-1:0] shift_t;
  typedef logic [ACC_BITS-1:0]   acc_t;

  // Register indexes on the configuration port (word addresses).
  typedef enum logic [1:0] {
    REG_TOUCH_ENABLED    = 2'd0,
    REG_POLL_INTERVAL_MS = 2'd1,
    REG_SMOOTHING_SHIFT  = 2'd2,
    REG_SCREEN_HEIGHT    = 2'd3
  } reg_index_t;

  // Reset values of the registers.
  localparam logic [15:0]     POLL_INTERVAL_RESET = 16'd20;
  localparam shift_t          SHIFT_RESET         = 4'd2;
  localparam coord_t          HEIGHT_RESET        = 12'd320;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  touch_count;
    logic [7:0]  x_high_byte;
    logic [7:0]  x_low_byte;
    logic [7:0]  y_high_byte;
    logic [7:0]  y_low_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic        pressed;
    logic        new_press;
  } out_item_t;

  // Exponential average: (old * (2^sh - 1) + raw) >> sh, done as a shift,
  // a subtract and an add. The sum stays below 2^(COORD_BITS + sh).
  function automatic coord_t blend(input coord_t old_val, input coord_t raw_val,
                                   input shift_t sh);
    acc_t old_ext;
    acc_t acc;
    old_ext = acc_t'(old_val);
    acc     = (old_ext << sh) - old_ext + acc_t'(raw_val);
    return coord_t'(acc >> sh);
  endfunction

endpackage

// ===== hw/rtl/touch_point_smoother.sv =====
// Touch point smoother top level: APB registers, sampling, averaging and
// the rotated result with a two-entry output buffer. Depends on tps_pkg.
//
// Usage: each input transaction on in_valid/in_stall/in_data is one poll of
// the touch controller. Every poll yields exactly one result transaction on
// out_valid/out_stall/out_data, in order.
// An accepted poll is registered into the result register, or into the skid
// register while the receiver stalls. Throughput is one poll per cycle while
// in_stall is low; the whole update (interval compare, shift-and-add average,
// mirror subtract) sits between the input handshake and the result register.
// A result register and a skid register decouple the two sides: while the
// receiver stalls, one more poll is still taken; in_stall rises only once
// both are full and falls as soon as the receiver takes a result.
// Reset (rst, synchronous, active high) clears the held point, the press
// history and the last sample time, empties the output buffer and sets the
// registers to enabled 0, interval 20 ms, shift 2, height 320.
// Registers are written over APB at byte addresses 0, 4, 8 and 12, by the
// user only while the block is idle (not enforced); pready is always high.
module touch_point_smoother (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tps_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tps_pkg::out_item_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tps_pkg::*;

  // Configuration registers.
  logic        touch_enabled;
  logic [15:0] poll_interval_ms;
  shift_t      smoothing_shift;
  coord_t      screen_height;

  // Filter state.
  coord_t      smoothed_x;
  coord_t      smoothed_y;
  logic        held_pressed;
  logic        previous_pressed;
  logic [31:0] last_sample_time;

  // Output buffer.
  out_item_t   skid_data;
  logic        skid_valid;

  reg_index_t  reg_sel;
  logic        cfg_write;

  coord_t      raw_x;
  coord_t      raw_y;
  logic [31:0] elapsed;
  logic        sample;
  logic        touch;
  coord_t      smoothed_x_next;
  coord_t      smoothed_y_next;
  logic        held_pressed_next;
  out_item_t   result;
  logic        accept;
  logic        take;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  // Register write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      touch_enabled    <= 1'b0;
      poll_interval_ms <= POLL_INTERVAL_RESET;
      smoothing_shift  <= SHIFT_RESET;
      screen_height    <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_TOUCH_ENABLED:    touch_enabled    <= pwdata[0];
        REG_POLL_INTERVAL_MS: poll_interval_ms <= pwdata[15:0];
        REG_SMOOTHING_SHIFT:  smoothing_shift  <= pwdata[SHIFT_BITS-1:0];
        REG_SCREEN_HEIGHT:    screen_height    <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read port.
  always_comb begin
    case (reg_sel)
      REG_TOUCH_ENABLED:    prdata = {31'b0, touch_enabled};
      REG_POLL_INTERVAL_MS: prdata = {16'b0, poll_interval_ms};
      REG_SMOOTHING_SHIFT:  prdata = {{(32-SHIFT_BITS){1'b0}}, smoothing_shift};
      REG_SCREEN_HEIGHT:    prdata = {{(32-COORD_BITS){1'b0}}, screen_height};
      default:              prdata = 32'b0;
    endcase
  end

  // Unpack the point and decide whether this poll is a fresh sample.
  assign raw_x   = {in_data.x_high_byte[3:0], in_data.x_low_byte};
  assign raw_y   = {in_data.y_high_byte[3:0], in_data.y_low_byte};
  assign elapsed = in_data.now_ms - last_sample_time;
  assign sample  = elapsed >= {16'b0, poll_interval_ms};
  assign touch   = (in_data.touch_count != 2'd0) && ((raw_x != '0) || (raw_y != '0));

  // Next held point: start, blend, release or hold.
  always_comb begin
    smoothed_x_next   = smoothed_x;
    smoothed_y_next   = smoothed_y;
    held_pressed_next = held_pressed;
    if (sample) begin
      held_pressed_next = touch;
      if (touch && held_pressed) begin
        smoothed_x_next = blend(smoothed_x, raw_x, smoothing_shift);
        smoothed_y_next = blend(smoothed_y, raw_y, smoothing_shift);
      end else if (touch) begin
        smoothed_x_next = raw_x;
        smoothed_y_next = raw_y;
      end
    end
  end

  // Rotated result; all zero while disabled or released.
  always_comb begin
    result = '0;
    if (touch_enabled && held_pressed_next) begin
      result.screen_x = smoothed_y_next;
      result.screen_y = (screen_height > smoothed_x_next) ?
                        (screen_height - smoothed_x_next) : '0;
      result.pressed  = 1'b1;
    end
    result.new_press = touch_enabled && held_pressed_next && !previous_pressed;
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  // Filter state update; a disabled poll leaves it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_x       <= '0;
      smoothed_y       <= '0;
      held_pressed     <= 1'b0;
      previous_pressed <= 1'b0;
      last_sample_time <= 32'b0;
    end else if (accept && touch_enabled) begin
      smoothed_x       <= smoothed_x_next;
      smoothed_y       <= smoothed_y_next;
      held_pressed     <= held_pressed_next;
      previous_pressed <= held_pressed_next;
      if (sample) begin
        last_sample_time <= in_data.now_ms;
      end
    end
  end

  // Output buffer control: result register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Output buffer data.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

endmodule

// ===== hw/rtl/tps_checker.sv =====
// Port-level checker for the touch point smoother and its bind statement.
// Depends on tps_pkg and touch_point_smoother_macros.svh.
`include "touch_point_smoother_macros.svh"

module tps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tps_pkg::out_item_t out_data
);
  import tps_pkg::*;

  // A released result carries no coordinates.
  `TPS_ASSERT_RST(a_released_zero, clk, rst, out_valid && !out_data.pressed |-> out_data.screen_x == 12'd0 && out_data.screen_y == 12'd0, "released result has coordinates")

  // A rising edge flag only comes with a pressed result.
  `TPS_ASSERT_RST(a_new_press_implies_pressed, clk, rst, out_valid && out_data.new_press |-> out_data.pressed, "new_press without pressed")

  // A stalled result stays in place.
  `TPS_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // The output buffer is empty right after reset.
  `TPS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid && !in_stall, "output buffer not empty after reset")

endmodule

bind touch_point_smoother tps_checker u_tps_checker (.*);

// ===== verif/tps_check_pkg.sv =====
// Scoreboard for the touch point smoother testbench: a bit-exact predictor
// of the poll sampling, averaging and rotation, plus the result checker.
// Depends on tps_pkg for the payload types, register codes and reset values.
package tps_check_pkg;
  import tps_pkg::*;

  class touch_scoreboard;
    // Shadow copy of the configuration registers.
    bit          enabled;
    logic [15:0] interval;
    shift_t      shift;
    coord_t      height;

    // Shadow copy of the tracking state.
    coord_t      avg_x;
    coord_t      avg_y;
    bit          held;
    bit          was_pressed;
    logic [31:0] last_ms;

    out_item_t   expected_q[$];
    int          errors;
    int          checked;
    int          pressed_seen;
    int          edges_seen;

    function new();
      enabled      = 1'b0;
      interval     = POLL_INTERVAL_RESET;
      shift        = SHIFT_RESET;
      height       = HEIGHT_RESET;
      avg_x        = '0;
      avg_y        = '0;
      held         = 1'b0;
      was_pressed  = 1'b0;
      last_ms      = '0;
      errors       = 0;
      checked      = 0;
      pressed_seen = 0;
      edges_seen   = 0;
    endfunction

    // Mirror a completed register write.
    function void set_register(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_TOUCH_ENABLED:    enabled  = value[0];
        REG_POLL_INTERVAL_MS: interval = value[15:0];
        REG_SMOOTHING_SHIFT:  shift    = value[3:0];
        REG_SCREEN_HEIGHT:    height   = value[11:0];
        default: ;
      endcase
    endfunction

    // Weighted average with the new sample weighted one over two to the shift.
    function coord_t smooth(coord_t old_v, coord_t raw_v);
      longint unsigned weight;
      longint unsigned acc;
      weight = (64'd1 << shift) - 64'd1;
      acc    = 64'(old_v) * weight + 64'(raw_v);
      return coord_t'(acc >> shift);
    endfunction

    // Predict the result of one accepted poll transaction and queue it.
    function void note_poll(in_item_t p);
      coord_t      raw_x;
      coord_t      raw_y;
      logic [31:0] gap;
      out_item_t   want;
      raw_x = {p.x_high_byte[3:0], p.x_low_byte};
      raw_y = {p.y_high_byte[3:0], p.y_low_byte};
      want  = '0;
      if (enabled) begin
        gap = p.now_ms - last_ms;
        // A poll is sampled only once the interval has elapsed.
        if (gap >= 32'(interval)) begin
          last_ms = p.now_ms;
          if (p.touch_count != 2'd0 && (raw_x != '0 || raw_y != '0)) begin
            if (held) begin
              avg_x = smooth(avg_x, raw_x);
              avg_y = smooth(avg_y, raw_y);
            end else begin
              avg_x = raw_x;
              avg_y = raw_y;
            end
            held = 1'b1;
          end else begin
            held = 1'b0;
          end
        end
        // Rotate the held point; the mirrored y saturates at zero.
        if (held) begin
          want.pressed  = 1'b1;
          want.screen_x = avg_y;
          want.screen_y = (height > avg_x) ? height - avg_x : '0;
        end
        want.new_press = held && !was_pressed;
        was_pressed = held;
      end
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one accepted result transaction with the oldest prediction.
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing expected", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (want.pressed) pressed_seen++;
        if (want.new_press) edges_seen++;
        if (got.screen_x !== want.screen_x)
          report_mismatch($sformatf("result %0d screen_x %0d, expected %0d",
                                    checked, got.screen_x, want.screen_x));
        if (got.screen_y !== want.screen_y)
          report_mismatch($sformatf("result %0d screen_y %0d, expected %0d",
                                    checked, got.screen_y, want.screen_y));
        if (got.pressed !== want.pressed)
          report_mismatch($sformatf("result %0d pressed %b, expected %b",
                                    checked, got.pressed, want.pressed));
        if (got.new_press !== want.new_press)
          report_mismatch($sformatf("result %0d new_press %b, expected %b",
                                    checked, got.new_press, want.new_press));
      end
    endtask
  endclass

endpackage

// ===== verif/tb.sv =====
// Top-level testbench for touch_point_smoother: drives polls, register
// writes and result stalls, and checks every result against the scoreboard.
// Depends on tps_pkg, tps_check_pkg and the touch_point_smoother RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tps_pkg::*;
  import tps_check_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  touch_scoreboard sb;
  int          send_idle_pct;
  int          stall_pct;
  int          polls_sent;
  int          settings_used;
  int          quiet_cycles;
  logic [31:0] cur_ms;

  touch_point_smoother dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls and a check of every accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: count cycles in which no transaction and no register write happens.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build one poll; the high nibbles of the high bytes carry junk.
  function automatic in_item_t make_poll(logic [31:0] t, logic [1:0] cnt, coord_t x,
                                         coord_t y, logic [3:0] junk_x, logic [3:0] junk_y);
    in_item_t p;
    p.now_ms      = t;
    p.touch_count = cnt;
    p.x_high_byte = {junk_x, x[11:8]};
    p.x_low_byte  = x[7:0];
    p.y_high_byte = {junk_y, y[11:8]};
    p.y_low_byte  = y[7:0];
    return p;
  endfunction

  // Advance the poll clock: mostly around the interval, sometimes a big jump.
  function automatic logic [31:0] next_poll_time();
    logic [31:0] gap;
    case ($urandom_range(9))
      0, 1:             gap = $urandom_range(32'(sb.interval));
      2, 3, 4, 5, 6, 7: gap = 32'(sb.interval) + $urandom_range(5);
      8:                gap = $urandom_range(3);
      default:          gap = $urandom;
    endcase
    cur_ms = cur_ms + gap;
    return cur_ms;
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(3))
      0:       return coord_t'($urandom_range(15));
      1:       return coord_t'($urandom_range(4095, 4080));
      default: return coord_t'($urandom_range(4095));
    endcase
  endfunction

  // Present one poll, with random idle cycles first, and wait for acceptance.
  task automatic send_poll(in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    sb.note_poll(p);
    polls_sent++;
  endtask

  // Hold off the sender until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
  endtask

  task automatic program_regs(logic en, logic [15:0] iv, shift_t sh, coord_t ht);
    drain();
    write_reg(REG_TOUCH_ENABLED, 32'(en));
    write_reg(REG_POLL_INTERVAL_MS, 32'(iv));
    write_reg(REG_SMOOTHING_SHIFT, 32'(sh));
    write_reg(REG_SCREEN_HEIGHT, 32'(ht));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // Random register setting that favors the extremes.
  task automatic program_random();
    logic        en;
    logic [15:0] iv;
    shift_t      sh;
    coord_t      ht;
    en = ($urandom_range(9) != 0);
    case ($urandom_range(4))
      0:       iv = 16'd0;
      1:       iv = 16'hFFFF;
      2:       iv = 16'($urandom_range(40, 1));
      3:       iv = 16'($urandom_range(65535));
      default: iv = 16'd20;
    endcase
    case ($urandom_range(3))
      0:       sh = 4'd0;
      1:       sh = 4'd15;
      2:       sh = 4'd8;
      default: sh = shift_t'($urandom_range(15));
    endcase
    case ($urandom_range(3))
      0:       ht = 12'd0;
      1:       ht = 12'hFFF;
      default: ht = coord_t'($urandom_range(4095));
    endcase
    program_regs(en, iv, sh, ht);
  endtask

  // Mostly strokes (a jittered press held for a few polls, then a release),
  // with some fully random polls mixed in.
  task automatic random_block(int n_polls);
    int     sent_here;
    int     len;
    coord_t bx;
    coord_t by;
    sent_here = 0;
    while (sent_here < n_polls) begin
      if ($urandom_range(9) < 7) begin
        bx  = pick_coord();
        by  = pick_coord();
        len = $urandom_range(8, 2);
        repeat (len) begin
          send_poll(make_poll(next_poll_time(), 2'($urandom_range(3, 1)),
                              bx + coord_t'($urandom_range(31)) - 12'd16,
                              by + coord_t'($urandom_range(31)) - 12'd16,
                              4'($urandom_range(15)), 4'($urandom_range(15))));
        end
        if ($urandom_range(1) == 0)
          send_poll(make_poll(next_poll_time(), 2'd0, coord_t'($urandom_range(4095)),
                              coord_t'($urandom_range(4095)),
                              4'($urandom_range(15)), 4'($urandom_range(15))));
        else
          send_poll(make_poll(next_poll_time(), 2'($urandom_range(3, 1)), '0, '0,
                              4'($urandom_range(15)), 4'($urandom_range(15))));
        sent_here += len + 1;
      end else begin
        send_poll(make_poll(next_poll_time(), 2'($urandom_range(3)),
                            coord_t'($urandom_range(4095)), coord_t'($urandom_range(4095)),
                            4'($urandom_range(15)), 4'($urandom_range(15))));
        sent_here++;
      end
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    polls_sent    = 0;
    settings_used = 0;
    cur_ms        = $urandom;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Touch is disabled out of reset, so a press gives an all-zero result.
    send_poll(make_poll(32'd100, 2'd1, 12'h123, 12'h456, 4'h0, 4'h0));

    // Start at the far corner, repeat within the interval, then blend.
    program_regs(1'b1, 16'd20, 4'd2, 12'd320);
    send_poll(make_poll(32'd100, 2'd1, 12'hFFF, 12'hFFF, 4'hF, 4'hF));
    send_poll(make_poll(32'd110, 2'd1, 12'h000, 12'h000, 4'h3, 4'hC));
    send_poll(make_poll(32'd120, 2'd1, 12'h000, 12'h800, 4'h0, 4'h0));
    send_poll(make_poll(32'd140, 2'd3, 12'h100, 12'h001, 4'h0, 4'h0));
    // A zero point releases even with junk in the high nibbles.
    send_poll(make_poll(32'd160, 2'd2, 12'h000, 12'h000, 4'hA, 4'h5));
    // No touch reported releases regardless of the coordinates.
    send_poll(make_poll(32'd180, 2'd0, 12'h0AB, 12'h0CD, 4'h0, 4'h0));
    send_poll(make_poll(32'd200, 2'd1, 12'd10, 12'd0, 4'h0, 4'h0));
    send_poll(make_poll(32'd219, 2'd1, 12'd99, 12'd99, 4'h0, 4'h0));
    send_poll(make_poll(32'd220, 2'd2, 12'd320, 12'd7, 4'h0, 4'h0));

    // Zero interval samples every poll; zero shift replaces; zero height.
    program_regs(1'b1, 16'd0, 4'd0, 12'd0);
    send_poll(make_poll(32'd220, 2'd1, 12'd5, 12'd9, 4'h0, 4'h0));
    send_poll(make_poll(32'd220, 2'd1, 12'hFFF, 12'hFFF, 4'h0, 4'h0));

    // Longest interval, heaviest averaging and full height.
    program_regs(1'b1, 16'hFFFF, 4'd15, 12'hFFF);
    send_poll(make_poll(32'd1000, 2'd1, 12'h800, 12'h800, 4'h0, 4'h0));
    send_poll(make_poll(32'd65755, 2'd1, 12'h800, 12'h800, 4'h0, 4'h0));
    send_poll(make_poll(32'd131289, 2'd1, 12'h001, 12'h001, 4'h0, 4'h0));
    send_poll(make_poll(32'd131290, 2'd1, 12'h001, 12'h001, 4'h0, 4'h0));

    // Time stamp wraps around between two sampled polls.
    program_regs(1'b1, 16'd20, 4'd8, 12'hFFF);
    send_poll(make_poll(32'hFFFF_FFF0, 2'd1, 12'h0FF, 12'h0FF, 4'h0, 4'h0));
    send_poll(make_poll(32'h0000_0005, 2'd1, 12'h0F0, 12'h00F, 4'h0, 4'h0));

    // Disabling blanks the result but keeps the held touch and its history.
    program_regs(1'b0, 16'd20, 4'd8, 12'hFFF);
    send_poll(make_poll(32'h0000_0100, 2'd1, 12'd1, 12'd1, 4'h0, 4'h0));
    program_regs(1'b1, 16'd20, 4'd8, 12'hFFF);
    send_poll(make_poll(32'h0000_0006, 2'd1, 12'd2, 12'd2, 4'h0, 4'h0));

    // Random part: three idling patterns, four register settings each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          stall_pct     = 62;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct     = 37;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        program_random();
        random_block(42);
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Covered %0d polls under %0d register settings, %0d results compared",
             polls_sent, settings_used, sb.checked);
    $display("(%0d while pressed, %0d new presses), %0d mismatches.",
             sb.pressed_seen, sb.edges_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
